FILE: hdl/ntc_voltage_to_temperature_assert.svh
// Assertion macros shared by the thermistor conversion RTL.
`ifndef NTC_VOLTAGE_TO_TEMPERATURE_ASSERT_SVH
`define NTC_VOLTAGE_TO_TEMPERATURE_ASSERT_SVH
`ifndef SYNTHESIS
// The enclosing module must provide clk and arst_n.
`define NTC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ntc assertion failed");
`define NTC_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("ntc forbidden condition seen");
`else
`define NTC_ASSERT(label, prop)
`define NTC_ASSERT_NEVER(label, cond)
`endif
`endif

FILE: hdl/ntc_pkg.sv
// Types and constants of the thermistor conversion block.
package ntc_pkg;

	localparam int LOG_FRAC_BITS = 24;
	localparam int RECIP_W = 47;
	localparam int SUM_W = 49;
	localparam int QC_W = 48;
	localparam int TK_W = 50;
	localparam int ABS_ZERO_CENTI = 27315;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [46:0] RECIP_ONE_CENTI = 47'd109951162777600;

	typedef enum logic [1:0] {
		CFG_DIV_OHMS = 2'd0,
		CFG_NOM_OHMS = 2'd1,
		CFG_NOM_TEMP = 2'd2,
		CFG_BETA     = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

	typedef struct packed {
		logic bad;
		logic zero;
		logic neg;
	} fin_flags_t;

endpackage

FILE: hdl/ntc_sense_if.sv
// Valid/ready channel carrying one divider voltage word.
interface ntc_sense_if;
	logic        valid;
	logic        ready;
	logic [11:0] sense_mv;
	modport source(output valid, output sense_mv, input ready);
	modport sink(input valid, input sense_mv, output ready);
endinterface

FILE: hdl/ntc_temp_if.sv
// Valid/ready channel carrying one temperature result word.
interface ntc_temp_if;
	import ntc_pkg::*;
	logic               valid;
	logic               ready;
	logic signed [15:0] temp_centi;
	status_t            status;
	modport source(output valid, output temp_centi, output status, input ready);
	modport sink(input valid, input temp_centi, input status, output ready);
endinterface

FILE: hdl/ntc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
module ntc_div_pipe #(
	parameter int NW = 47,
	parameter int DW = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quot,
	output logic [SW-1:0] side_out
);

	logic          vld_s  [NW];
	logic [NW-1:0] nq_s   [NW];
	logic [DW-1:0] rem_s  [NW];
	logic [DW-1:0] den_s  [NW];
	logic [SW-1:0] side_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic          p_vld;
		logic [NW-1:0] p_nq;
		logic [DW-1:0] p_rem;
		logic [DW-1:0] p_den;
		logic [SW-1:0] p_side;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign p_vld  = in_valid;
			assign p_nq   = num;
			assign p_rem  = '0;
			assign p_den  = den;
			assign p_side = side_in;
		end else begin : g_next
			assign p_vld  = vld_s[k-1];
			assign p_nq   = nq_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_den  = den_s[k-1];
			assign p_side = side_s[k-1];
		end

		// The dividend shifts out at the top while quotient bits shift in below.
		assign trial = {p_rem, p_nq[NW-1]};
		assign ge    = trial >= {1'b0, p_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[k]   <= {p_nq[NW-2:0], ge};
				rem_s[k]  <= ge ? DW'(trial - {1'b0, p_den}) : trial[DW-1:0];
				den_s[k]  <= p_den;
				side_s[k] <= p_side;
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign quot      = nq_s[NW-1];
	assign side_out  = side_s[NW-1];

endmodule

FILE: hdl/ntc_voltage_to_temperature.sv
// NTC thermistor divider voltage to temperature converter, beta equation.
//
// Usage: each word on the sense channel carries one divider voltage in mV; for
// every accepted word exactly one word leaves on the temp channel, in order,
// holding the temperature in 0.01 degC and a status code. Words move on a
// rising edge with valid and ready both high.
// A new word can be taken every cycle while the pipeline is not held; the 24
// squaring stages of the base-2 log and the three one-bit-per-stage dividers
// set the depth.
// The configuration registers are written through cfg_we, cfg_index and cfg_wdata;
// the user writes them only while no word is in flight, the block does not enforce it.
// Reset clears all valid bits and the output queue and loads the default
// divider, nominal resistance, nominal temperature and beta values.
// When the receiver stalls, a two-word output queue keeps taking finished
// results; once it is full and ready stays low, the whole pipeline holds and
// sense.ready drops, so no word is lost or repeated.
`include "ntc_voltage_to_temperature_assert.svh"
module ntc_voltage_to_temperature #(
	parameter int SUPPLY_MV = 3300
) (
	input  logic                clk,
	input  logic                arst_n,
	ntc_sense_if.sink           sense,
	ntc_temp_if.source          temp,
	input  logic                cfg_we,
	input  ntc_pkg::cfg_index_t cfg_index,
	input  logic [19:0]         cfg_wdata
);
	import ntc_pkg::*;

	localparam int NLOG = LOG_FRAC_BITS + 1;
	localparam logic [11:0] SUPPLY_LIT = 12'(SUPPLY_MV);

	function automatic logic [4:0] msb_idx(input logic [31:0] x);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) begin
				r = 5'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [30:0] norm_mant(input logic [31:0] x, input logic [4:0] top);
		logic [31:0] sh;
		sh = x << (5'd31 - top);
		return sh[31:1];
	endfunction

	// Configuration registers.
	logic [19:0]        div_ohms_q;
	logic [19:0]        nom_ohms_q;
	logic [15:0]        nom_temp_q;
	logic [13:0]        beta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_ohms_q <= 20'd10000;
			nom_ohms_q <= 20'd10000;
			nom_temp_q <= 16'd2500;
			beta_q     <= 14'd3950;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DIV_OHMS: div_ohms_q <= cfg_wdata;
				CFG_NOM_OHMS: nom_ohms_q <= cfg_wdata;
				CFG_NOM_TEMP: nom_temp_q <= cfg_wdata[15:0];
				CFG_BETA:     beta_q     <= cfg_wdata[13:0];
			endcase
		end
	end

	logic        run;
	logic [1:0]  cnt_q;

	// Stage 1: range check, divider products, effective registers.
	logic [19:0] rdiv_eff;
	logic [19:0] rnom_eff;
	logic [13:0] beta_eff;
	logic [16:0] t0_sum;
	logic [15:0] t0k_eff;
	logic [11:0] v_in;

	assign v_in     = sense.sense_mv;
	assign rdiv_eff = (div_ohms_q == '0) ? 20'd1 : div_ohms_q;
	assign rnom_eff = (nom_ohms_q == '0) ? 20'd1 : nom_ohms_q;
	assign beta_eff = (beta_q == '0) ? 14'd1 : beta_q;
	assign t0_sum   = {nom_temp_q[15], nom_temp_q} + 17'(ABS_ZERO_CENTI);
	assign t0k_eff  = (t0_sum[16] || t0_sum == '0) ? 16'd1 : t0_sum[15:0];

	logic        vld_s1;
	logic        bad_s1;
	logic [31:0] num_s1;
	logic [31:0] den_s1;
	logic [15:0] t0k_s1;
	logic [13:0] beta_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (run) begin
			vld_s1 <= sense.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			bad_s1  <= (v_in <= 12'd1) || (v_in >= SUPPLY_LIT);
			num_s1  <= {12'b0, rdiv_eff} * {20'b0, SUPPLY_LIT - v_in};
			den_s1  <= {20'b0, v_in} * {12'b0, rnom_eff};
			t0k_s1  <= t0k_eff;
			beta_s1 <= beta_eff;
		end
	end

	// Log stages: index 0 is the normalized mantissa, then one squaring per stage.
	// Lane 0 is the numerator, lane 1 the denominator.
	logic [30:0] mant_s [2][NLOG];
	logic [23:0] frac_s [2][NLOG];
	logic [4:0]  top_s  [2][NLOG];
	logic        vld_lg_s  [NLOG];
	logic        bad_lg_s  [NLOG];
	logic [15:0] t0k_lg_s  [NLOG];
	logic [13:0] beta_lg_s [NLOG];

	logic [4:0]  top_n;
	logic [4:0]  top_d;
	assign top_n = msb_idx(num_s1);
	assign top_d = msb_idx(den_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_lg_s[0] <= 1'b0;
		end else if (run) begin
			vld_lg_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			mant_s[0][0] <= norm_mant(num_s1, top_n);
			mant_s[1][0] <= norm_mant(den_s1, top_d);
			top_s[0][0]  <= top_n;
			top_s[1][0]  <= top_d;
			frac_s[0][0] <= '0;
			frac_s[1][0] <= '0;
			bad_lg_s[0]  <= bad_s1;
			t0k_lg_s[0]  <= t0k_s1;
			beta_lg_s[0] <= beta_s1;
		end
	end

	for (genvar j = 0; j < LOG_FRAC_BITS; j++) begin : g_sq
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [61:0] sq;
			logic [31:0] t;

			// A square of 2 or more yields a one fraction bit and renormalizes.
			assign sq = 62'(mant_s[l][j]) * 62'(mant_s[l][j]);
			assign t  = sq[61:30];

			always_ff @(posedge clk) begin
				if (run) begin
					mant_s[l][j+1] <= t[31] ? t[31:1] : t[30:0];
					frac_s[l][j+1] <= {frac_s[l][j][22:0], t[31]};
					top_s[l][j+1]  <= top_s[l][j];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_lg_s[j+1] <= 1'b0;
			end else if (run) begin
				vld_lg_s[j+1] <= vld_lg_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (run) begin
				bad_lg_s[j+1]  <= bad_lg_s[j];
				t0k_lg_s[j+1]  <= t0k_lg_s[j];
				beta_lg_s[j+1] <= beta_lg_s[j];
			end
		end
	end

	// Natural log of the resistance ratio as sign and magnitude.
	logic [28:0] lv_n;
	logic [28:0] lv_d;
	logic        lv_lt;
	assign lv_n  = {top_s[0][NLOG-1], frac_s[0][NLOG-1]};
	assign lv_d  = {top_s[1][NLOG-1], frac_s[1][NLOG-1]};
	assign lv_lt = lv_n < lv_d;

	logic        vld_l1, vld_l2, vld_l3;
	logic        bad_l1, bad_l2, bad_l3;
	logic        neg_l1, neg_l2, neg_l3;
	logic [15:0] t0k_l1, t0k_l2, t0k_l3;
	logic [13:0] beta_l1, beta_l2, beta_l3;
	logic [28:0] mag_l1;
	logic [58:0] prod_l2;
	logic [28:0] lnmag_l3;
	logic [59:0] ln_rnd;

	assign ln_rnd = {1'b0, prod_l2} + (60'd1 << 29);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_l1 <= 1'b0;
			vld_l2 <= 1'b0;
			vld_l3 <= 1'b0;
		end else if (run) begin
			vld_l1 <= vld_lg_s[NLOG-1];
			vld_l2 <= vld_l1;
			vld_l3 <= vld_l2;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			bad_l1   <= bad_lg_s[NLOG-1];
			t0k_l1   <= t0k_lg_s[NLOG-1];
			beta_l1  <= beta_lg_s[NLOG-1];
			neg_l1   <= lv_lt;
			mag_l1   <= lv_lt ? lv_d - lv_n : lv_n - lv_d;
			bad_l2   <= bad_l1;
			t0k_l2   <= t0k_l1;
			beta_l2  <= beta_l1;
			neg_l2   <= neg_l1;
			prod_l2  <= 59'(mag_l1) * 59'(LN2_Q30);
			bad_l3   <= bad_l2;
			t0k_l3   <= t0k_l2;
			beta_l3  <= beta_l2;
			neg_l3   <= neg_l2;
			lnmag_l3 <= ln_rnd[58:30];
		end
	end

	// Two parallel dividers: ln(r)/B and 1/T0, both rounded half away from zero.
	logic [RECIP_W-1:0] num_a;
	logic [RECIP_W-1:0] num_b;
	logic [RECIP_W-1:0] qa;
	logic [RECIP_W-1:0] qb;
	logic               va;
	logic               vb;
	logic               bad_a;
	logic               neg_b;

	assign num_a = {2'b0, lnmag_l3, 16'b0} + RECIP_W'(beta_l3 >> 1);
	assign num_b = RECIP_ONE_CENTI + RECIP_W'(t0k_l3 >> 1);

	ntc_div_pipe #(.NW(RECIP_W), .DW(14), .SW(1)) u_div_lnb (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (run),
		.in_valid  (vld_l3),
		.num       (num_a),
		.den       (beta_l3),
		.side_in   (bad_l3),
		.out_valid (va),
		.quot      (qa),
		.side_out  (bad_a)
	);

	ntc_div_pipe #(.NW(RECIP_W), .DW(16), .SW(1)) u_div_t0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (run),
		.in_valid  (vld_l3),
		.num       (num_b),
		.den       (t0k_l3),
		.side_in   (neg_l3),
		.out_valid (vb),
		.quot      (qb),
		.side_out  (neg_b)
	);

	// Reciprocal sum and its magnitude.
	logic             vld_c1, vld_c2;
	logic             bad_c1;
	logic [SUM_W-1:0] sum_c1;
	logic [SUM_W-1:0] sum_neg;
	fin_flags_t       fl_c2;
	logic [QC_W-1:0]  mag_c2;

	assign sum_neg = -sum_c1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c1 <= 1'b0;
			vld_c2 <= 1'b0;
		end else if (run) begin
			vld_c1 <= va & vb;
			vld_c2 <= vld_c1;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			bad_c1     <= bad_a;
			sum_c1     <= neg_b ? {2'b0, qb} - {2'b0, qa} : {2'b0, qb} + {2'b0, qa};
			fl_c2.bad  <= bad_c1;
			fl_c2.zero <= sum_c1 == '0;
			fl_c2.neg  <= sum_c1[SUM_W-1];
			mag_c2     <= sum_c1[SUM_W-1] ? sum_neg[QC_W-1:0] : sum_c1[QC_W-1:0];
		end
	end

	// Final reciprocal back to hundredths of a kelvin.
	logic [QC_W-1:0] num_c;
	logic [QC_W-1:0] den_c;
	logic [QC_W-1:0] qc;
	logic            vc;
	fin_flags_t      fl_c;

	assign num_c = QC_W'(RECIP_ONE_CENTI) + {1'b0, mag_c2[QC_W-1:1]};
	assign den_c = fl_c2.zero ? QC_W'(1) : mag_c2;

	ntc_div_pipe #(.NW(QC_W), .DW(QC_W), .SW($bits(fin_flags_t))) u_div_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (run),
		.in_valid  (vld_c2),
		.num       (num_c),
		.den       (den_c),
		.side_in   (fl_c2),
		.out_valid (vc),
		.quot      (qc),
		.side_out  (fl_c)
	);

	logic                   vld_f1;
	fin_flags_t             fl_f1;
	logic signed [TK_W-1:0] tk_f1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f1 <= 1'b0;
		end else if (run) begin
			vld_f1 <= vc;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			fl_f1 <= fl_c;
			tk_f1 <= fl_c.neg ? -$signed({2'b0, qc}) : $signed({2'b0, qc});
		end
	end

	// Celsius conversion, range status and saturation.
	logic signed [TK_W-1:0] tc;
	logic signed [15:0]     new_temp;
	status_t                new_st;

	assign tc = tk_f1 - TK_W'(ABS_ZERO_CENTI);

	always_comb begin
		if (fl_f1.bad) begin
			new_temp = 16'sd0;
			new_st   = ST_RANGE;
		end else if (fl_f1.zero || tc > TK_W'(32767)) begin
			new_temp = 16'sd32767;
			new_st   = ST_SAT;
		end else if (tc < -TK_W'(32768)) begin
			new_temp = -16'sd32768;
			new_st   = ST_SAT;
		end else begin
			new_temp = tc[15:0];
			new_st   = ST_OK;
		end
	end

	// Two-word output queue; entry 0 is the head.
	logic               push;
	logic               pop;
	logic signed [15:0] e0_temp_q, e1_temp_q;
	status_t            e0_st_q, e1_st_q;

	assign run  = (cnt_q != 2'd2) || temp.ready;
	assign push = run && vld_f1;
	assign pop  = temp.valid && temp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && cnt_q == 2'd1) begin
				e0_temp_q <= new_temp;
				e0_st_q   <= new_st;
			end else begin
				e0_temp_q <= e1_temp_q;
				e0_st_q   <= e1_st_q;
			end
			if (push && cnt_q == 2'd2) begin
				e1_temp_q <= new_temp;
				e1_st_q   <= new_st;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				e0_temp_q <= new_temp;
				e0_st_q   <= new_st;
			end else begin
				e1_temp_q <= new_temp;
				e1_st_q   <= new_st;
			end
		end
	end

	assign temp.valid      = cnt_q != 2'd0;
	assign temp.temp_centi = e0_temp_q;
	assign temp.status     = e0_st_q;
	assign sense.ready     = run;

	`NTC_ASSERT_NEVER(a_div_lanes_aligned, va != vb)
	`NTC_ASSERT_NEVER(a_queue_count_range, cnt_q == 2'd3)
	`NTC_ASSERT(a_range_gives_zero, temp.valid && temp.status == ST_RANGE |-> temp.temp_centi == 16'sd0)
	`NTC_ASSERT(a_hold_only_when_full, !run |-> cnt_q == 2'd2 && !temp.ready)

endmodule
